### src/adsr_sweep_pulse_noise_voice_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ADSR pulse/noise voice
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef ADSR_SWEEP_PULSE_NOISE_VOICE_UNIT_DEFINES_SVH
`define ADSR_SWEEP_PULSE_NOISE_VOICE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle implication violated");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### src/asvp_pkg.sv
// ----------------------------------------------------------------------------
// asvp_pkg
// Shared types and constants of the ADSR pulse/noise voice.
// ----------------------------------------------------------------------------
`default_nettype none

package asvp_pkg;

	localparam int DEF_SAMPLE_RATE = 44100;
	localparam int DEF_LENGTH_BITS = 16;

	localparam int PER_W      = 26;	// period and phase, 1/256 sample units
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SAMPLE_W   = 8;

	localparam logic [15:0] LFSR_SEED  = 16'hACE1;
	localparam logic [7:0]  DUTY_RESET = 8'd128;
	localparam logic [15:0] FREQ_MIN   = 16'd12;
	localparam logic [15:0] FREQ_LIMIT = 16'd22050;
	localparam logic [7:0]  LEVEL_MAX  = 8'd127;
	localparam logic [7:0]  AMP_FULL   = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AD_LEN  = 3'd0,
		REG_SR_LEN  = 3'd1,
		REG_SA_FREQ = 3'd2,
		REG_SR_FREQ = 3'd3,
		REG_PEAK    = 3'd4,
		REG_HOLD    = 3'd5,
		REG_DUTY    = 3'd6,
		REG_NOISE   = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_MOD,
		S_BND,
		S_AMUL,
		S_ADIV,
		S_FMUL,
		S_FDIV,
		S_PST,
		S_PDIV,
		S_MST,
		S_MDIV,
		S_LEVEL,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

### src/asvp_if.sv
// ----------------------------------------------------------------------------
// asvp_if
// Valid/ready channels of the voice: tick input, sample output, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface asvp_in_if;
	logic valid;
	logic ready;
	logic start_req;
	modport source(output valid, output start_req, input ready);
	modport sink(input valid, input start_req, output ready);
endinterface

interface asvp_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [asvp_pkg::SAMPLE_W-1:0] sample;
	logic                                active;
	modport source(output valid, output sample, output active, input ready);
	modport sink(input valid, input sample, input active, output ready);
endinterface

interface asvp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [asvp_pkg::CFG_IDX_W-1:0]  index;
	logic [asvp_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/asvp_div.sv
// ----------------------------------------------------------------------------
// asvp_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module asvp_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 26
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo,
	output logic      [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;	// dividend bits out, quotient bits in
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### src/adsr_sweep_pulse_noise_voice_unit.sv
// ----------------------------------------------------------------------------
// adsr_sweep_pulse_noise_voice_unit
// One pulse/noise voice with a piecewise-linear ADSR amplitude and pitch sweep.
// ----------------------------------------------------------------------------
// Usage: every beat on in_ch is one sample tick; start_req restarts the note.
// Each tick yields exactly one beat on out_ch (sample, active). Registers are
// written over cfg (index = register number); the user must write them only
// while the voice is idle, which the block does not enforce; cfg is always ready.
// Flow: one tick at a time. A silent tick goes from evaluation straight to
// the output; a tick inside a waveform period takes the level step between
// them. A tick on a period boundary runs the shared serial divider four times
// (amplitude ramp, pitch ramp, period, level scale), plus once more for the
// phase wrap; the first tick of a note, or one with a zero period, skips the
// phase wrap. The dividend is DN = max(16 + min(LENGTH_BITS,16), 26) bits,
// and the divider produces one quotient bit per cycle. A finished result sits
// in an output register; the next tick is accepted while it waits, and only
// the handoff of the following result stalls.
// Reset: registers take their reset values, voice silent, LFSR at 0xACE1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adsr_sweep_pulse_noise_voice_unit_defines.svh"

module adsr_sweep_pulse_noise_voice_unit #(
	parameter int SAMPLE_RATE = asvp_pkg::DEF_SAMPLE_RATE,
	parameter int LENGTH_BITS = asvp_pkg::DEF_LENGTH_BITS
) (
	input wire logic    clk,
	input wire logic    arst_n,
	asvp_in_if.sink     in_ch,
	asvp_out_if.source  out_ch,
	asvp_cfg_if.sink    cfg
);

	localparam int PER_W  = asvp_pkg::PER_W;
	localparam int LF_W   = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
	localparam int T_W    = LF_W + 2;
	localparam int PROD_W = 16 + LF_W;
	localparam int DN     = (PROD_W > PER_W) ? PROD_W : PER_W;
	localparam int DD     = PER_W;
	localparam logic [DN-1:0] SR256 = DN'(SAMPLE_RATE * 256);

	// configuration
	logic [31:0] ad_len_q, sr_len_q, sa_freq_q, sr_freq_q;
	logic [7:0]  peak_q, hold_q, duty_q;
	logic        noise_q;

	// voice state
	asvp_pkg::state_t   state_q, state_d;
	logic [T_W-1:0]     note_q;
	logic [PER_W-1:0]   phase_q;
	logic [PER_W-1:0]   period_q;
	logic signed [7:0]  lvl1_q, lvl2_q;
	logic               playing_q;
	logic [15:0]        lfsr_q;

	// boundary work registers
	logic [LF_W-1:0]    x_q, d_q;
	logic [7:0]         afrom_q, ato_q, amp_q;
	logic [15:0]        ffrom_q, fto_q, freq_q;
	logic               neg_q;
	logic signed [7:0]  res_sample_q;
	logic               res_active_q;

	// output register
	logic               out_valid_q;
	logic signed [7:0]  out_sample_q;
	logic               out_active_q;

	// divider
	logic               div_start;
	logic [DN-1:0]      div_num;
	logic [DD-1:0]      div_den;
	logic               div_done;
	logic [DN-1:0]      div_quo;
	logic [DD-1:0]      div_rem;

	logic               in_acc, out_free;
	logic [LF_W-1:0]    la, ld, ls, lr;
	logic [T_W-1:0]     e1, e2, e3, total_c;
	logic [15:0]        fi;
	logic               silent_c, bnd_c, clr_c;
	logic signed [16:0] diff_c;
	logic [15:0]        diff_mag_c;
	logic [PROD_W-1:0]  prod_c;
	logic [15:0]        freq_c;
	logic [14:0]        mag_num_c;
	logic signed [9:0]  amp_new_c;
	logic signed [17:0] freq_new_c;
	logic [6:0]         mag_c;
	logic               b1_c, b2_c;
	logic [15:0]        l1_c, l2_c;
	logic [33:0]        ph_scaled_c, duty_lim_c;
	logic signed [7:0]  level_c;

	assign la = ad_len_q[LF_W-1:0];
	assign ld = ad_len_q[16 +: LF_W];
	assign ls = sr_len_q[LF_W-1:0];
	assign lr = sr_len_q[16 +: LF_W];
	assign e1      = T_W'(la);
	assign e2      = e1 + T_W'(ld);
	assign e3      = e2 + T_W'(ls);
	assign total_c = e3 + T_W'(lr);
	assign fi      = sa_freq_q[15:0];

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	assign silent_c = !playing_q || (note_q >= total_c);
	assign bnd_c    = (note_q == '0) || (phase_q >= period_q);
	assign clr_c    = (note_q == '0) || (period_q == '0);

	// ramp product |to - from| * x, amplitude or frequency by state
	always_comb begin
		if (state_q == asvp_pkg::S_FMUL)
			diff_c = $signed({1'b0, fto_q}) - $signed({1'b0, ffrom_q});
		else
			diff_c = $signed({9'b0, ato_q}) - $signed({9'b0, afrom_q});
		diff_mag_c = diff_c[16] ? 16'(-diff_c) : diff_c[15:0];
		prod_c = {{LF_W{1'b0}}, diff_mag_c} * {16'b0, x_q};
	end

	assign freq_c    = (freq_q == 16'd0) ? 16'd1 : freq_q;
	assign mag_num_c = 15'(amp_q) * 15'(asvp_pkg::LEVEL_MAX);

	assign amp_new_c = $signed({2'b0, afrom_q})
		+ (neg_q ? -$signed({2'b0, div_quo[7:0]}) : $signed({2'b0, div_quo[7:0]}));
	assign freq_new_c = $signed({2'b0, ffrom_q})
		+ (neg_q ? -$signed({2'b0, div_quo[15:0]}) : $signed({2'b0, div_quo[15:0]}));
	assign mag_c = div_quo[6:0];

	// two LFSR steps, taps 16,14,13,11, shifting right
	assign b1_c = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
	assign l1_c = {b1_c, lfsr_q[15:1]};
	assign b2_c = l1_c[0] ^ l1_c[2] ^ l1_c[3] ^ l1_c[5];
	assign l2_c = {b2_c, l1_c[15:1]};

	assign ph_scaled_c = {phase_q, 8'b0};
	assign duty_lim_c  = 34'(period_q) * 34'(duty_q);
	always_comb begin
		if (ph_scaled_c < duty_lim_c)
			level_c = lvl1_q;
		else if (phase_q < period_q)
			level_c = lvl2_q;
		else
			level_c = '0;
	end

	// config writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_len_q  <= '0;
			sr_len_q  <= '0;
			sa_freq_q <= '0;
			sr_freq_q <= '0;
			peak_q    <= '0;
			hold_q    <= '0;
			duty_q    <= asvp_pkg::DUTY_RESET;
			noise_q   <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (asvp_pkg::cfg_reg_t'(cfg.index))
				asvp_pkg::REG_AD_LEN:  ad_len_q  <= cfg.data;
				asvp_pkg::REG_SR_LEN:  sr_len_q  <= cfg.data;
				asvp_pkg::REG_SA_FREQ: sa_freq_q <= cfg.data;
				asvp_pkg::REG_SR_FREQ: sr_freq_q <= cfg.data;
				asvp_pkg::REG_PEAK:    peak_q    <= cfg.data[7:0];
				asvp_pkg::REG_HOLD:    hold_q    <= cfg.data[7:0];
				asvp_pkg::REG_DUTY:    duty_q    <= cfg.data[7:0];
				asvp_pkg::REG_NOISE:   noise_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			asvp_pkg::S_IDLE:  if (in_acc) state_d = asvp_pkg::S_EVAL;
			asvp_pkg::S_EVAL: begin
				if (silent_c)
					state_d = asvp_pkg::S_EMIT;
				else if (bnd_c)
					state_d = clr_c ? asvp_pkg::S_BND : asvp_pkg::S_MOD;
				else
					state_d = asvp_pkg::S_LEVEL;
			end
			asvp_pkg::S_MOD:   if (div_done) state_d = asvp_pkg::S_BND;
			asvp_pkg::S_BND:   state_d = asvp_pkg::S_AMUL;
			asvp_pkg::S_AMUL:  state_d = asvp_pkg::S_ADIV;
			asvp_pkg::S_ADIV:  if (div_done) state_d = asvp_pkg::S_FMUL;
			asvp_pkg::S_FMUL:  state_d = asvp_pkg::S_FDIV;
			asvp_pkg::S_FDIV:  if (div_done) state_d = asvp_pkg::S_PST;
			asvp_pkg::S_PST:   state_d = asvp_pkg::S_PDIV;
			asvp_pkg::S_PDIV:  if (div_done) state_d = asvp_pkg::S_MST;
			asvp_pkg::S_MST:   state_d = asvp_pkg::S_MDIV;
			asvp_pkg::S_MDIV:  if (div_done) state_d = asvp_pkg::S_LEVEL;
			asvp_pkg::S_LEVEL: state_d = asvp_pkg::S_EMIT;
			asvp_pkg::S_EMIT:  if (out_free) state_d = asvp_pkg::S_IDLE;
			default:           state_d = asvp_pkg::S_IDLE;
		endcase
	end

	// divider operands
	always_comb begin
		div_start = 1'b0;
		div_num   = DN'(phase_q);
		div_den   = period_q;
		case (state_q)
			asvp_pkg::S_EVAL: div_start = !silent_c && bnd_c && !clr_c;
			asvp_pkg::S_AMUL, asvp_pkg::S_FMUL: begin
				div_start = 1'b1;
				div_num   = DN'(prod_c);
				div_den   = DD'(d_q);
			end
			asvp_pkg::S_PST: begin
				div_start = 1'b1;
				div_num   = SR256;
				div_den   = DD'(freq_c);
			end
			asvp_pkg::S_MST: begin
				div_start = 1'b1;
				div_num   = DN'(mag_num_c);
				div_den   = DD'(asvp_pkg::AMP_FULL);
			end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == asvp_pkg::S_IDLE);

	asvp_div #(
		.NUM_W(DN),
		.DEN_W(DD)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// control and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= asvp_pkg::S_IDLE;
			note_q      <= '0;
			phase_q     <= '0;
			period_q    <= '0;
			lvl1_q      <= '0;
			lvl2_q      <= '0;
			playing_q   <= 1'b0;
			lfsr_q      <= asvp_pkg::LFSR_SEED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				asvp_pkg::S_IDLE: begin
					if (in_acc && in_ch.start_req) begin
						note_q    <= '0;
						phase_q   <= '0;
						playing_q <= (fi >= asvp_pkg::FREQ_MIN)
							&& (fi < asvp_pkg::FREQ_LIMIT);
					end
				end
				asvp_pkg::S_EVAL: begin
					if (silent_c)
						playing_q <= 1'b0;
					else if (bnd_c && clr_c)
						phase_q <= '0;
				end
				asvp_pkg::S_MOD:   if (div_done) phase_q <= div_rem;
				asvp_pkg::S_PDIV:  if (div_done) period_q <= div_quo[PER_W-1:0];
				asvp_pkg::S_MDIV: begin
					if (div_done) begin
						if (noise_q) begin
							lvl1_q <= b1_c ? $signed({1'b0, mag_c}) : -$signed({1'b0, mag_c});
							lvl2_q <= b2_c ? $signed({1'b0, mag_c}) : -$signed({1'b0, mag_c});
							lfsr_q <= l2_c;
						end else begin
							lvl1_q <= $signed({1'b0, mag_c});
							lvl2_q <= -$signed({1'b0, mag_c});
						end
					end
				end
				asvp_pkg::S_LEVEL: begin
					phase_q <= phase_q + PER_W'(256);
					note_q  <= note_q + 1'b1;
				end
				default: ;
			endcase
			if (state_q == asvp_pkg::S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			asvp_pkg::S_EVAL: begin
				res_sample_q <= '0;
				res_active_q <= 1'b0;
			end
			asvp_pkg::S_BND: begin
				if (note_q < e1) begin
					x_q     <= LF_W'(note_q);
					d_q     <= la;
					afrom_q <= '0;
					ato_q   <= peak_q;
					ffrom_q <= fi;
					fto_q   <= sa_freq_q[31:16];
				end else if (note_q < e2) begin
					x_q     <= LF_W'(note_q - e1);
					d_q     <= ld;
					afrom_q <= peak_q;
					ato_q   <= hold_q;
					ffrom_q <= sa_freq_q[31:16];
					fto_q   <= sr_freq_q[15:0];
				end else if (note_q < e3) begin
					x_q     <= '0;
					d_q     <= LF_W'(1);
					afrom_q <= hold_q;
					ato_q   <= hold_q;
					ffrom_q <= sr_freq_q[15:0];
					fto_q   <= sr_freq_q[15:0];
				end else if (note_q < total_c) begin
					x_q     <= LF_W'(note_q - e3);
					d_q     <= lr;
					afrom_q <= hold_q;
					ato_q   <= '0;
					ffrom_q <= sr_freq_q[15:0];
					fto_q   <= sr_freq_q[31:16];
				end else begin
					x_q     <= '0;
					d_q     <= LF_W'(1);
					afrom_q <= '0;
					ato_q   <= '0;
					ffrom_q <= sr_freq_q[31:16];
					fto_q   <= sr_freq_q[31:16];
				end
			end
			asvp_pkg::S_AMUL, asvp_pkg::S_FMUL: neg_q <= diff_c[16];
			asvp_pkg::S_ADIV: if (div_done) amp_q <= amp_new_c[7:0];
			asvp_pkg::S_FDIV: if (div_done) freq_q <= freq_new_c[15:0];
			asvp_pkg::S_LEVEL: begin
				res_sample_q <= level_c;
				res_active_q <= 1'b1;
			end
			default: ;
		endcase
		if (state_q == asvp_pkg::S_EMIT && out_free) begin
			out_sample_q <= res_sample_q;
			out_active_q <= res_active_q;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.sample = out_sample_q;
	assign out_ch.active = out_active_q;

	`ASSERT_IMPLY(a_div_done_waits, clk, arst_n, div_done, (state_q == asvp_pkg::S_MOD || state_q == asvp_pkg::S_ADIV || state_q == asvp_pkg::S_FDIV || state_q == asvp_pkg::S_PDIV || state_q == asvp_pkg::S_MDIV))
	`ASSERT_IMPLY(a_idle_is_silent, clk, arst_n, out_valid_q && !out_active_q, out_sample_q == 8'sd0)
	`ASSERT_NEXT(a_tick_evaluated, clk, arst_n, in_acc, state_q == asvp_pkg::S_EVAL)

endmodule

`default_nettype wire
